// ===== rtl/sag_pkg.sv =====
// Shared constants, record types and the infection threshold table of the SEIRS agent grid.
package sag_pkg;

  localparam int AGENTS        = 32768;
  localparam int GRID          = 256;
  localparam int NEIGHBOR_CAP  = 31;
  localparam int DURATION_BITS = 14;

  localparam int AGENT_AW = $clog2(AGENTS);
  localparam int COORD_W  = $clog2(GRID);
  localparam int CELLS    = GRID * GRID;
  localparam int CELL_AW  = 2 * COORD_W;
  localparam int CELL_W   = 16;
  localparam int CNT_W    = 16;
  localparam int SUM_W    = $clog2(NEIGHBOR_CAP + 1);
  localparam int NB_CELLS = 9;

  localparam logic [DURATION_BITS-1:0] DUR_MAX = {DURATION_BITS{1'b1}};

  // exp(-0.5) in Q0.32.
  localparam logic [64:0] EXP_HALF_Q32 = 65'd2605029347;

  // Function codes.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // Status codes.
  localparam logic [1:0] STAT_S = 2'd0;
  localparam logic [1:0] STAT_E = 2'd1;
  localparam logic [1:0] STAT_I = 2'd2;
  localparam logic [1:0] STAT_R = 2'd3;

  // One agent record as held in the agent memory; loaded stays clear until the first load.
  typedef struct packed {
    logic                     loaded;
    logic [1:0]               status;
    logic [DURATION_BITS-1:0] days;
    logic [DURATION_BITS-1:0] dur_e;
    logic [DURATION_BITS-1:0] dur_i;
    logic [DURATION_BITS-1:0] dur_r;
    logic [COORD_W-1:0]       x;
    logic [COORD_W-1:0]       y;
  } agent_rec_t;

  // Population counter update request.
  typedef struct packed {
    logic       en;
    logic       dec_en;
    logic [1:0] dec_idx;
    logic       inc_en;
    logic [1:0] inc_idx;
  } cnt_upd_t;

  typedef logic [31:0] thr_tab_t [0:NEIGHBOR_CAP];

  // Builds thr[n] = 2^32 - exp(-0.5)^n in Q0.32, clipped to 32 bits.
  function automatic thr_tab_t build_thr();
    thr_tab_t    t;
    logic [64:0] q;
    logic [64:0] v;
    q    = 65'd1 << 32;
    t[0] = 32'd0;
    for (int n = 1; n <= NEIGHBOR_CAP; n++) begin
      q    = (q * EXP_HALF_Q32 + (65'd1 << 31)) >> 32;
      v    = (65'd1 << 32) - q;
      t[n] = (v > 65'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    end
    return t;
  endfunction

  localparam thr_tab_t THR = build_thr();

  // Column and row offset codes (0..2) of neighborhood step k.
  function automatic logic [3:0] nb_off(input logic [3:0] k);
    logic [3:0] r;
    case (k)
      4'd0:    r = {2'd0, 2'd0};
      4'd1:    r = {2'd0, 2'd1};
      4'd2:    r = {2'd0, 2'd2};
      4'd3:    r = {2'd1, 2'd0};
      4'd4:    r = {2'd1, 2'd1};
      4'd5:    r = {2'd1, 2'd2};
      4'd6:    r = {2'd2, 2'd0};
      4'd7:    r = {2'd2, 2'd1};
      4'd8:    r = {2'd2, 2'd2};
      default: r = {2'd1, 2'd1};
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/sag_ram.sv =====
// Generic simple dual-port RAM with a registered read.
module sag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/sag_counts.sv =====
// Population counters for the four SEIRS states.
module sag_counts (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sag_pkg::cnt_upd_t                    upd,
  output logic [3:0][sag_pkg::CNT_W-1:0]       counts
);
  import sag_pkg::*;

  logic [3:0][CNT_W-1:0] cnt_r;
  logic [3:0][CNT_W-1:0] cnt_nxt;

  // Decrement stops at zero; the increment applies after it.
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      cnt_nxt[i] = cnt_r[i];
      if (upd.en && upd.dec_en && upd.dec_idx == 2'(i) && cnt_r[i] != '0) begin
        cnt_nxt[i] = cnt_r[i] - 1'b1;
      end
      if (upd.en && upd.inc_en && upd.inc_idx == 2'(i)) begin
        cnt_nxt[i] = cnt_nxt[i] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign counts = cnt_r;

endmodule

// ===== rtl/seirs_agent_grid_update.sv =====
// Top level of the SEIRS agent grid update: sequencer over the agent and cell memories.
//
//  channel  | handshake         | ports
//  ---------+-------------------+---------------------------------------------
//  input    | start && !busy    | in_func in_agent in_pos_x/y in_init_status
//           |                   | in_dur_* in_draw
//  result   | out_valid strobe  | out_new_status out_count_s/e/i/r
//
// An update of a susceptible agent reads the nine neighborhood cells in turn through
// the single read port of the cell memory, which also serves the per-cell
// read-modify-writes of loads and of other updates.
// After reset a clearing pass writes all 65536 cell counts, one per cycle, and marks
// every agent record unloaded on the way; busy stays high throughout the pass.
// Each result beat is held for one cycle only, since the receiver cannot stall;
// the next item is taken once busy falls.
module seirs_agent_grid_update (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic                              in_func,
  input  logic [14:0]                       in_agent,
  input  logic [7:0]                        in_pos_x,
  input  logic [7:0]                        in_pos_y,
  input  logic [1:0]                        in_init_status,
  input  logic [13:0]                       in_dur_exposed,
  input  logic [13:0]                       in_dur_infectious,
  input  logic [13:0]                       in_dur_recovered,
  input  logic [31:0]                       in_draw,
  output logic                              out_valid,
  output logic [1:0]                        out_new_status,
  output logic [15:0]                       out_count_s,
  output logic [15:0]                       out_count_e,
  output logic [15:0]                       out_count_i,
  output logic [15:0]                       out_count_r
);
  import sag_pkg::*;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_DECIDE = 4'd2;
  localparam logic [3:0] ST_DEC_RD = 4'd3;
  localparam logic [3:0] ST_DEC_WR = 4'd4;
  localparam logic [3:0] ST_INC_RD = 4'd5;
  localparam logic [3:0] ST_INC_WR = 4'd6;
  localparam logic [3:0] ST_NB     = 4'd7;
  localparam logic [3:0] ST_TEST   = 4'd8;
  localparam logic [3:0] ST_FIN    = 4'd9;
  localparam logic [3:0] ST_OUT    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  // Captured command.
  logic                     func_r;
  logic [AGENT_AW-1:0]      agent_r;
  logic [COORD_W-1:0]       x_r;
  logic [COORD_W-1:0]       y_r;
  logic [1:0]               st_in_r;
  logic [DURATION_BITS-1:0] dur_e_r;
  logic [DURATION_BITS-1:0] dur_i_r;
  logic [DURATION_BITS-1:0] dur_r_r;
  logic [31:0]              draw_r;

  // Work plan.
  agent_rec_t          rec_r;
  logic [COORD_W-1:0]  old_x_r;
  logic [COORD_W-1:0]  old_y_r;
  logic                inc_new_r;
  cnt_upd_t            upd_r;
  logic [3:0]          k_r;
  logic [SUM_W-1:0]    sum_r;
  logic [CELL_AW-1:0]  clr_addr_r;

  // Memory ports.
  agent_rec_t          agent_rdata;
  logic                agent_re;
  logic                agent_we;
  logic [AGENT_AW-1:0] agent_waddr;
  agent_rec_t          agent_wdata;
  logic [CELL_W-1:0]   cell_rdata;
  logic                cell_re;
  logic                cell_we;
  logic [CELL_AW-1:0]  cell_raddr;
  logic [CELL_AW-1:0]  cell_waddr;
  logic [CELL_W-1:0]   cell_wdata;

  cnt_upd_t              cnt_upd;
  logic [3:0][CNT_W-1:0] counts;

  // Update plan from the stored record.
  logic [DURATION_BITS-1:0] days1;
  logic                     tr_e;
  logic                     tr_i;
  logic                     tr_r;
  agent_rec_t               plan_rec;
  cnt_upd_t                 plan_upd;
  logic                     plan_inc;
  agent_rec_t               expo_rec;
  logic [3:0]               off;
  logic [CELL_W:0]          sum_add;
  logic                     accept;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);

  always_comb begin
    days1 = (agent_rdata.days == DUR_MAX) ? agent_rdata.days : agent_rdata.days + 1'b1;
    tr_e  = agent_rdata.loaded && (agent_rdata.status == STAT_E) &&
            (days1 >= agent_rdata.dur_e);
    tr_i  = agent_rdata.loaded && (agent_rdata.status == STAT_I) &&
            (days1 >= agent_rdata.dur_i);
    tr_r  = agent_rdata.loaded && (agent_rdata.status == STAT_R) &&
            (days1 >= agent_rdata.dur_r);
  end

  // New record, counter move and cell increment chosen at the decision step.
  // An update of an agent never loaded leaves everything as it is and reports status 0.
  always_comb begin
    plan_rec = '0;
    plan_upd = '0;
    plan_inc = 1'b0;
    if (func_r == FUNC_LOAD) begin
      plan_rec = '{loaded: 1'b1, status: st_in_r, days: '0, dur_e: dur_e_r,
                   dur_i: dur_i_r, dur_r: dur_r_r, x: x_r, y: y_r};
      plan_inc = (st_in_r == STAT_I);
      plan_upd = '{en: 1'b1, dec_en: agent_rdata.loaded, dec_idx: agent_rdata.status,
                   inc_en: 1'b1, inc_idx: st_in_r};
    end else if (agent_rdata.loaded) begin
      plan_rec      = agent_rdata;
      plan_rec.x    = x_r;
      plan_rec.y    = y_r;
      plan_rec.days = (tr_e || tr_i || tr_r) ? '0 : days1;
      plan_inc      = ((agent_rdata.status == STAT_I) && !tr_i) || tr_e;
      plan_upd      = '{en: 1'b1, dec_en: 1'b0, dec_idx: STAT_S, inc_en: 1'b0,
                        inc_idx: STAT_S};
      if (tr_e) begin
        plan_rec.status = STAT_I;
        plan_upd        = '{en: 1'b1, dec_en: 1'b1, dec_idx: STAT_E, inc_en: 1'b1,
                            inc_idx: STAT_I};
      end else if (tr_i) begin
        plan_rec.status = STAT_R;
        plan_upd        = '{en: 1'b1, dec_en: 1'b1, dec_idx: STAT_I, inc_en: 1'b1,
                            inc_idx: STAT_R};
      end else if (tr_r) begin
        plan_rec.status = STAT_S;
        plan_upd        = '{en: 1'b1, dec_en: 1'b1, dec_idx: STAT_R, inc_en: 1'b1,
                            inc_idx: STAT_S};
      end
    end
  end

  // Record of a susceptible agent that has just been exposed.
  always_comb begin
    expo_rec        = rec_r;
    expo_rec.status = STAT_E;
    expo_rec.days   = '0;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLR:    if (clr_addr_r == CELL_AW'(CELLS - 1)) state_nxt = ST_IDLE;
      ST_IDLE:   if (start) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (func_r == FUNC_LOAD) begin
          if (agent_rdata.loaded && agent_rdata.status == STAT_I) state_nxt = ST_DEC_RD;
          else if (st_in_r == STAT_I)                             state_nxt = ST_INC_RD;
          else                                                    state_nxt = ST_FIN;
        end else begin
          if (!agent_rdata.loaded)                state_nxt = ST_FIN;
          else if (agent_rdata.status == STAT_I)  state_nxt = ST_DEC_RD;
          else if (tr_e)                          state_nxt = ST_INC_RD;
          else if (agent_rdata.status == STAT_S)  state_nxt = ST_NB;
          else                                    state_nxt = ST_FIN;
        end
      end
      ST_DEC_RD: state_nxt = ST_DEC_WR;
      ST_DEC_WR: state_nxt = inc_new_r ? ST_INC_RD : ST_FIN;
      ST_INC_RD: state_nxt = ST_INC_WR;
      ST_INC_WR: state_nxt = ST_FIN;
      ST_NB:     if (k_r == 4'(NB_CELLS)) state_nxt = ST_TEST;
      ST_TEST:   state_nxt = ST_FIN;
      ST_FIN:    state_nxt = ST_OUT;
      ST_OUT:    state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLR;
      clr_addr_r <= '0;
      k_r        <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (state_r == ST_DECIDE) begin
        k_r <= '0;
      end else if (state_r == ST_NB) begin
        k_r <= k_r + 1'b1;
      end
    end
  end

  assign sum_add = {1'b0, cell_rdata} + (CELL_W + 1)'(sum_r);

  // Command capture and record assembly.
  always_ff @(posedge clk) begin
    if (accept) begin
      func_r  <= in_func;
      agent_r <= in_agent;
      x_r     <= in_pos_x;
      y_r     <= in_pos_y;
      st_in_r <= in_init_status;
      dur_e_r <= in_dur_exposed;
      dur_i_r <= in_dur_infectious;
      dur_r_r <= in_dur_recovered;
      draw_r  <= in_draw;
    end
    if (state_r == ST_DECIDE) begin
      old_x_r   <= agent_rdata.x;
      old_y_r   <= agent_rdata.y;
      sum_r     <= '0;
      rec_r     <= plan_rec;
      inc_new_r <= plan_inc;
      upd_r     <= plan_upd;
    end
    // Neighborhood sum, capped as it grows.
    if (state_r == ST_NB && k_r != 4'd0) begin
      sum_r <= (sum_add > (CELL_W + 1)'(NEIGHBOR_CAP)) ? SUM_W'(NEIGHBOR_CAP)
                                                      : sum_add[SUM_W-1:0];
    end
    // Infection test of a susceptible agent.
    if (state_r == ST_TEST && draw_r < THR[sum_r]) begin
      rec_r <= expo_rec;
      upd_r <= '{en: 1'b1, dec_en: 1'b1, dec_idx: STAT_S, inc_en: 1'b1,
                 inc_idx: STAT_E};
    end
  end

  // Cell memory port steering.
  always_comb begin
    off        = nb_off(k_r);
    cell_we    = 1'b0;
    cell_waddr = {old_x_r, old_y_r};
    cell_wdata = '0;
    cell_re    = 1'b0;
    cell_raddr = {old_x_r, old_y_r};
    case (state_r)
      ST_CLR: begin
        cell_we    = 1'b1;
        cell_waddr = clr_addr_r;
      end
      ST_DEC_RD: cell_re = 1'b1;
      ST_DEC_WR: begin
        cell_we    = 1'b1;
        cell_wdata = (cell_rdata == '0) ? '0 : cell_rdata - 1'b1;
      end
      ST_INC_RD: begin
        cell_re    = 1'b1;
        cell_raddr = {rec_r.x, rec_r.y};
      end
      ST_INC_WR: begin
        cell_we    = 1'b1;
        cell_waddr = {rec_r.x, rec_r.y};
        cell_wdata = cell_rdata + 1'b1;
      end
      ST_NB: begin
        cell_re    = (k_r < 4'(NB_CELLS));
        cell_raddr = {rec_r.x + COORD_W'(off[3:2]) - COORD_W'(1),
                      rec_r.y + COORD_W'(off[1:0]) - COORD_W'(1)};
      end
      default: ;
    endcase
  end

  // Agent memory: cleared to unloaded records during the clearing pass.
  assign agent_re    = accept;
  assign agent_we    = (state_r == ST_FIN) || (state_r == ST_CLR);
  assign agent_waddr = (state_r == ST_CLR) ? clr_addr_r[AGENT_AW-1:0] : agent_r;
  assign agent_wdata = (state_r == ST_CLR) ? agent_rec_t'('0) : rec_r;

  sag_ram #(
    .WIDTH ($bits(agent_rec_t)),
    .DEPTH (AGENTS)
  ) u_agent_ram (
    .clk   (clk),
    .we    (agent_we),
    .waddr (agent_waddr),
    .wdata (agent_wdata),
    .re    (agent_re),
    .raddr (in_agent),
    .rdata (agent_rdata)
  );

  sag_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cell_ram (
    .clk   (clk),
    .we    (cell_we),
    .waddr (cell_waddr),
    .wdata (cell_wdata),
    .re    (cell_re),
    .raddr (cell_raddr),
    .rdata (cell_rdata)
  );

  // Counters change at the end of the finishing cycle.
  always_comb begin
    cnt_upd    = upd_r;
    cnt_upd.en = upd_r.en && (state_r == ST_FIN);
  end

  sag_counts u_counts (
    .clk    (clk),
    .rst_n  (rst_n),
    .upd    (cnt_upd),
    .counts (counts)
  );

  // Result beat.
  assign out_valid      = (state_r == ST_OUT);
  assign out_new_status = rec_r.status;
  assign out_count_s    = counts[STAT_S];
  assign out_count_e    = counts[STAT_E];
  assign out_count_i    = counts[STAT_I];
  assign out_count_r    = counts[STAT_R];

  a_out_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r) == ST_FIN)
    else $error("result beat without a finished record write");
  a_out_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result beat longer than one cycle");
  a_accept_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> state_r == ST_DECIDE)
    else $error("accepted item did not reach the decision step");
  a_sum_capped: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST) |-> sum_r <= SUM_W'(NEIGHBOR_CAP))
    else $error("neighborhood sum above cap");
  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cell_we && cell_re))
    else $error("cell memory read and write in one cycle");

endmodule
